### rtl/core/lshr_pkg.sv
package lshr_pkg;

  // Field widths of the poll word, the report word and the interval register.
  localparam int unsigned LevelW    = 14;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned AxisW     = 8;
  localparam int unsigned IntervalW = 16;

  // Interval after reset, in milliseconds.
  localparam logic [IntervalW-1:0] ResetInterval = 16'd100;

  // Axis offsets.
  localparam logic [AxisW-1:0] AxisXOffset = 8'd127;
  localparam logic [AxisW-1:0] AxisYOffset = 8'd128;

  // Contact positions in switch_levels (active low).
  localparam int unsigned CT_JOY     = 0;
  localparam int unsigned CT_LEFT    = 1;
  localparam int unsigned CT_RIGHT   = 2;
  localparam int unsigned CT_MARKERS = 3;
  localparam int unsigned CT_LOW     = 4;
  localparam int unsigned CT_HIGH    = 5;
  localparam int unsigned CT_FFOG    = 6;
  localparam int unsigned CT_RFOG    = 7;
  localparam int unsigned CT_WINT    = 8;
  localparam int unsigned CT_WLO     = 9;
  localparam int unsigned CT_WHI     = 10;
  localparam int unsigned CT_RWIPE   = 11;
  localparam int unsigned CT_SPRAYF  = 12;
  localparam int unsigned CT_SPRAYR  = 13;

  // Button positions in the report.
  localparam int unsigned BT_JOY     = 0;
  localparam int unsigned BT_LEFT    = 1;
  localparam int unsigned BT_RIGHT   = 2;
  localparam int unsigned BT_OFF     = 3;
  localparam int unsigned BT_MARKERS = 4;
  localparam int unsigned BT_LOW     = 5;
  localparam int unsigned BT_HIGH    = 6;
  localparam int unsigned BT_FFOG    = 7;
  localparam int unsigned BT_UP      = 8;
  localparam int unsigned BT_DOWN    = 9;
  localparam int unsigned BT_RFOG    = 10;
  localparam int unsigned BT_SPRAYF  = 11;
  localparam int unsigned BT_SPRAYR  = 12;
  localparam int unsigned BT_RWIPE   = 13;

  // Kept position of the light lever.
  typedef enum logic [1:0] {
    LIGHT_OFF     = 2'd0,
    LIGHT_MARKERS = 2'd1,
    LIGHT_LOW     = 2'd2
  } light_pos_t;

  // Wiper lever positions: off, interval, low, high.
  typedef logic [1:0] wiper_pos_t;
  localparam wiper_pos_t WIPER_OFF  = 2'd0;
  localparam wiper_pos_t WIPER_INT  = 2'd1;
  localparam wiper_pos_t WIPER_LOW  = 2'd2;
  localparam wiper_pos_t WIPER_HIGH = 2'd3;

  // One poll word.
  typedef struct packed {
    logic [LevelW-1:0]  switch_levels;
    logic [TimeW-1:0]   now_ms;
    logic [SampleW-1:0] stick_x_sample;
    logic [SampleW-1:0] stick_y_sample;
  } poll_t;

  // One report word.
  typedef struct packed {
    logic signed [AxisW-1:0] axis_x;
    logic signed [AxisW-1:0] axis_y;
    logic [LevelW-1:0]       buttons;
  } report_t;

  // Lever state carried from one poll to the next.
  typedef struct packed {
    logic [LevelW-1:0] buttons;
    logic [TimeW-1:0]  last_time;
    logic              rwipe;
    light_pos_t        light;
    wiper_pos_t        wiper;
  } lever_state_t;

  localparam lever_state_t StateReset = '{
    buttons:   '0,
    last_time: '0,
    rwipe:     1'b0,
    light:     LIGHT_OFF,
    wiper:     WIPER_OFF
  };

endpackage

### rtl/core/lshr_if.sv
// Poll channel: one word per lever scan.
interface lshr_poll_if
  import lshr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LevelW-1:0]  switch_levels;
  logic [TimeW-1:0]   now_ms;
  logic [SampleW-1:0] stick_x_sample;
  logic [SampleW-1:0] stick_y_sample;

  modport source (
    output valid, switch_levels, now_ms, stick_x_sample, stick_y_sample,
    input  ready
  );
  modport sink (
    input  valid, switch_levels, now_ms, stick_x_sample, stick_y_sample,
    output ready
  );
endinterface

// Report channel: one word per poll.
interface lshr_report_if
  import lshr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [AxisW-1:0] axis_x;
  logic signed [AxisW-1:0] axis_y;
  logic [LevelW-1:0]       buttons;

  modport source (
    output valid, axis_x, axis_y, buttons,
    input  ready
  );
  modport sink (
    input  valid, axis_x, axis_y, buttons,
    output ready
  );
endinterface

### rtl/core/lever_switch_hid_report.sv
// Channel   Direction  Carries
// poll      in         switch_levels, now_ms, stick_x_sample, stick_y_sample
// report    out        axis_x, axis_y, buttons
// cfg       in         cfg_we, cfg_data (repeat interval in ms)
//
// One word per cycle sustained while the report is not stalled; an
// accepted poll goes into the input register, then the report register.
// The lever state is updated as a word moves from the input register into
// the report register, so consecutive polls see each other's effect.
// While the report is stalled the input register still takes one word.
// rst is synchronous and clears both valid bits, the lever state and sets
// the interval to 100 ms.
module lever_switch_hid_report
  import lshr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IntervalW-1:0] cfg_data,
  lshr_poll_if.sink            poll,
  lshr_report_if.source        report
);

  logic                 s1_valid;
  poll_t                s1_item;
  logic                 out_valid;
  report_t              out_rep;
  lever_state_t         state;
  lever_state_t         state_next;
  report_t              rep_next;
  logic [IntervalW-1:0] interval;
  logic                 advance;

  // The report register frees when empty or taken; the input register follows.
  assign advance    = !out_valid || report.ready;
  assign poll.ready = !s1_valid || advance;

  lshr_step u_step (
    .poll_word (s1_item),
    .cur       (state),
    .interval  (interval),
    .nxt       (state_next),
    .rep       (rep_next)
  );

  // Control, lever state and the interval register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= StateReset;
      interval  <= ResetInterval;
    end else begin
      if (cfg_we) begin
        interval <= cfg_data;
      end
      if (poll.ready) begin
        s1_valid <= poll.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (s1_valid && advance) begin
        state <= state_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_item <= '{switch_levels:  poll.switch_levels,
                   now_ms:         poll.now_ms,
                   stick_x_sample: poll.stick_x_sample,
                   stick_y_sample: poll.stick_y_sample};
    end
    if (s1_valid && advance) begin
      out_rep <= rep_next;
    end
  end

  assign report.valid   = out_valid;
  assign report.axis_x  = out_rep.axis_x;
  assign report.axis_y  = out_rep.axis_y;
  assign report.buttons = out_rep.buttons;

  // A word in the input register reaches the report register when it frees.
  a_move: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> out_valid)
    else $error("input word not moved to the report register");

  // Lever state changes only when a word is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && advance) |=> $stable(state))
    else $error("lever state changed without a word");

  // At most one light pulse and one wiper pulse pending at a time.
  a_light_pulse: assert property (@(posedge clk) disable iff (rst)
    $onehot0(state.buttons[BT_LOW:BT_OFF]) && $onehot0(state.buttons[BT_DOWN:BT_UP]))
    else $error("more than one lever pulse pending");

  // With both registers full and the report stalled, no new poll is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !report.ready |-> !poll.ready)
    else $error("poll accepted while both registers are full");

endmodule

### rtl/core/lshr_step.sv
module lshr_step
  import lshr_pkg::*;
(
  input  poll_t                poll_word,
  input  lever_state_t         cur,
  input  logic [IntervalW-1:0] interval,
  output lever_state_t         nxt,
  output report_t              rep
);

  logic [LevelW-1:0] lev;
  logic [LevelW-1:0] b;
  logic [TimeW-1:0]  elapsed;
  logic              due;
  logic              rw;
  light_pos_t        lp;
  wiper_pos_t        wp;

  assign lev = poll_word.switch_levels;

  // Elapsed time since the last timed update, wrapping modulo 2^32.
  assign elapsed = poll_word.now_ms - cur.last_time;
  assign due     = elapsed > {{(TimeW-IntervalW){1'b0}}, interval};

  // Requested lever positions; higher contacts take priority.
  assign rw = ~lev[CT_RWIPE];
  assign lp = !lev[CT_LOW]     ? LIGHT_LOW :
              !lev[CT_MARKERS] ? LIGHT_MARKERS : LIGHT_OFF;
  assign wp = !lev[CT_WHI]  ? WIPER_HIGH :
              !lev[CT_WLO]  ? WIPER_LOW  :
              !lev[CT_WINT] ? WIPER_INT  : WIPER_OFF;

  // Plain buttons every poll, then the timed lever logic when it is due.
  always_comb begin
    nxt = cur;
    b   = cur.buttons;
    b[BT_JOY]    = ~lev[CT_JOY];
    b[BT_LEFT]   = ~lev[CT_LEFT];
    b[BT_RIGHT]  = ~lev[CT_RIGHT];
    b[BT_HIGH]   = ~lev[CT_HIGH];
    b[BT_FFOG]   = ~lev[CT_FFOG];
    b[BT_RFOG]   = ~lev[CT_RFOG];
    b[BT_SPRAYF] = ~lev[CT_SPRAYF];
    b[BT_SPRAYR] = ~lev[CT_SPRAYR];
    if (due) begin
      nxt.last_time = poll_word.now_ms;
      // The rear wiper pulses on every change of its contact.
      b[BT_RWIPE] = (rw != cur.rwipe);
      nxt.rwipe   = rw;
      // A pending light pulse is cleared before the lever is sampled again.
      if (b[BT_OFF]) begin
        b[BT_OFF] = 1'b0;
      end else if (b[BT_MARKERS]) begin
        b[BT_MARKERS] = 1'b0;
      end else if (b[BT_LOW]) begin
        b[BT_LOW] = 1'b0;
      end else if (lp != cur.light) begin
        nxt.light = lp;
        case (lp)
          LIGHT_LOW:     b[BT_LOW] = 1'b1;
          LIGHT_MARKERS: b[BT_MARKERS] = 1'b1;
          default:       b[BT_OFF] = 1'b1;
        endcase
      end
      // The wiper walks one step per pulse towards the lever position.
      if (b[BT_UP]) begin
        b[BT_UP] = 1'b0;
      end else if (b[BT_DOWN]) begin
        b[BT_DOWN] = 1'b0;
      end else if (wp > cur.wiper) begin
        b[BT_UP]  = 1'b1;
        nxt.wiper = cur.wiper + 2'd1;
      end else if (wp < cur.wiper) begin
        b[BT_DOWN] = 1'b1;
        nxt.wiper  = cur.wiper - 2'd1;
      end
    end
    nxt.buttons = b;
  end

  // Stick axes: divide by 16 is the top nibble-shift of the sample.
  assign rep.axis_x  = AxisXOffset - poll_word.stick_x_sample[SampleW-1 -: AxisW];
  assign rep.axis_y  = poll_word.stick_y_sample[SampleW-1 -: AxisW] - AxisYOffset;
  assign rep.buttons = nxt.buttons;

endmodule
